[rtl/assert_macros.svh]
// assertion macros shared by the converter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/cdn_pkg.sv]
// shared types, constants and the month length function for the day number converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cdn_pkg;

  localparam int SERIAL_W    = 22;
  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int ACC_W       = 23;
  localparam int QUOT_W      = 12;
  localparam int REM_W       = 11;
  localparam int PROD_W      = 2 * SERIAL_W;
  localparam int RECIP_SHIFT = 32;

  localparam int unsigned CYCLE_DAYS = 1461;
  localparam int unsigned LEAP_DAYS  = 366;
  localparam int unsigned YEAR_DAYS  = 365;

  // ceil(2^32 / 1461): exact quotient for every 22-bit dividend
  localparam logic [SERIAL_W-1:0] RECIP_1461 = 22'd2939745;

  localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
  localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;

  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEBR  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

  localparam logic KIND_TO_SERIAL = 1'b0;
  localparam logic KIND_TO_DATE   = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_REM   = 7'b0001000,
    S_YEAR  = 7'b0010000,
    S_MONTH = 7'b0100000,
    S_DONE  = 7'b1000000
  } cdn_state_t;

  typedef struct packed {
    logic load;
    logic quot_step;
    logic rem_step;
    logic year_fix;
    logic month_step;
    logic emit;
  } cdn_cmd_t;

  typedef struct packed {
    logic kind;
    logic err;
    logic month_done;
  } cdn_status_t;

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic [YEAR_W-1:0] y);
    logic [DAY_W-1:0] d;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAYS_LONG;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = DAYS_SHORT;
      MONTH_FEBR: d = (y[1:0] == 2'b00) ? DAYS_FEB_LEAP : DAYS_FEB;
      default:    d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/cdn_ctrl.sv]
// sequencer for the day number converter: setup, divide, remainder, year fix, month walk, emit
// depends on cdn_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cdn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cdn_pkg::cdn_status_t status,
  output cdn_pkg::cdn_cmd_t    cmd
);
  import cdn_pkg::*;

  cdn_state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (status.err) begin
          state_next = S_DONE;
        end else if (status.kind == KIND_TO_DATE) begin
          state_next = S_DIV;
        end else begin
          state_next = S_MONTH;
        end
      end
      S_DIV: begin
        cmd.quot_step = 1'b1;
        state_next    = S_REM;
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
        state_next   = S_YEAR;
      end
      S_YEAR: begin
        cmd.year_fix = 1'b1;
        state_next   = S_MONTH;
      end
      S_MONTH: begin
        if (status.month_done) begin
          state_next = S_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      S_DONE: begin
        // hold here while the output register is still full
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPL(a_emit_into_free_slot, clk, rst, cmd.emit, !out_valid || out_ready)
  `ASSERT_NEXT(a_quot_then_rem, clk, rst, cmd.quot_step, cmd.rem_step)
  `ASSERT_NEXT(a_rem_then_year_fix, clk, rst, cmd.rem_step, cmd.year_fix)

endmodule

`default_nettype wire

[rtl/cdn_dp.sv]
// datapath for the day number converter: range check, reciprocal divide by 1461,
// year split, month walk and the output register; depends on cdn_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cdn_dp #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           kind,
  input  logic [cdn_pkg::DAY_W-1:0]      day_of_month,
  input  logic [cdn_pkg::MONTH_W-1:0]    month_in,
  input  logic [cdn_pkg::YEAR_W-1:0]     year_in,
  input  logic [cdn_pkg::SERIAL_W-1:0]   serial_in,
  input  cdn_pkg::cdn_cmd_t              cmd,
  output cdn_pkg::cdn_status_t           status,
  output logic [cdn_pkg::SERIAL_W-1:0]   serial_out,
  output logic [cdn_pkg::DAY_W-1:0]      day_out,
  output logic [cdn_pkg::MONTH_W-1:0]    month_out,
  output logic [cdn_pkg::YEAR_W-1:0]     year_out,
  output logic                           range_error
);
  import cdn_pkg::*;

  localparam int unsigned SerialMax = (MAX_YEAR + 1) * YEAR_DAYS + MAX_YEAR / 4 + 1;

  logic                 kind_r, err_r;
  logic [ACC_W-1:0]     acc;
  logic [QUOT_W-1:0]    quot;
  logic [YEAR_W-1:0]    year_r;
  logic [MONTH_W-1:0]   month_r, mcnt;

  logic                 in_err;
  logic [ACC_W-1:0]     date_base;
  logic [PROD_W-1:0]    prod;
  logic [ACC_W-1:0]     cycle_base;
  logic [REM_W-1:0]     yr_r1, yr_rem;
  logic [YEAR_W-1:0]    yr_base, yr_year;
  logic [DAY_W-1:0]     dim;
  logic                 ok_date, ok_serial;

  // range check on the incoming beat
  always_comb begin
    if (kind == KIND_TO_SERIAL) begin
      in_err = (month_in == '0) || (month_in > MONTH_LAST) || (day_of_month == '0) ||
               (32'(year_in) > MAX_YEAR);
    end else begin
      in_err = (serial_in == '0) || (32'(serial_in) > SerialMax);
    end
  end

  // days before the year plus the day; the month walk adds the rest
  assign date_base = ACC_W'(year_in) * ACC_W'(YEAR_DAYS)
                   + ACC_W'((15'(year_in) + 15'd3) >> 2)
                   + ACC_W'(day_of_month);

  // quotient by reciprocal multiply, then the remainder in the next cycle
  assign prod       = PROD_W'(acc[SERIAL_W-1:0]) * PROD_W'(RECIP_1461);
  assign cycle_base = ACC_W'(quot) * ACC_W'(CYCLE_DAYS);

  // split the remainder of a four-year cycle into year and day of year
  always_comb begin
    yr_base = {quot, 2'b00};
    yr_r1   = acc[REM_W-1:0] - REM_W'(LEAP_DAYS);
    yr_rem  = acc[REM_W-1:0];
    yr_year = yr_base;
    if (acc >= ACC_W'(LEAP_DAYS)) begin
      if (yr_r1 >= REM_W'(2 * YEAR_DAYS)) begin
        yr_year = yr_base + YEAR_W'(3);
        yr_rem  = yr_r1 - REM_W'(2 * YEAR_DAYS);
      end else if (yr_r1 >= REM_W'(YEAR_DAYS)) begin
        yr_year = yr_base + YEAR_W'(2);
        yr_rem  = yr_r1 - REM_W'(YEAR_DAYS);
      end else begin
        yr_year = yr_base + YEAR_W'(1);
        yr_rem  = yr_r1;
      end
    end
  end

  assign dim = days_in_month(mcnt, year_r);

  always_comb begin
    status.kind = kind_r;
    status.err  = err_r;
    if (kind_r == KIND_TO_SERIAL) begin
      status.month_done = (mcnt == month_r);
    end else begin
      status.month_done = (mcnt == MONTH_LAST) || (acc < ACC_W'(dim));
    end
  end

  assign ok_date   = !err_r && (kind_r == KIND_TO_DATE);
  assign ok_serial = !err_r && (kind_r == KIND_TO_SERIAL);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind;
      err_r   <= in_err;
      month_r <= month_in;
      year_r  <= year_in;
      mcnt    <= MONTH_FIRST;
      quot    <= '0;
      if (kind == KIND_TO_DATE) begin
        acc <= ACC_W'(serial_in) - ACC_W'(1);
      end else begin
        acc <= date_base;
      end
    end else if (cmd.quot_step) begin
      quot <= prod[PROD_W-1:RECIP_SHIFT];
    end else if (cmd.rem_step) begin
      acc <= acc - cycle_base;
    end else if (cmd.year_fix) begin
      acc    <= ACC_W'(yr_rem);
      year_r <= yr_year;
    end else if (cmd.month_step) begin
      if (kind_r == KIND_TO_DATE) begin
        acc <= acc - ACC_W'(dim);
      end else begin
        acc <= acc + ACC_W'(dim);
      end
      mcnt <= mcnt + 1'b1;
    end
    if (cmd.emit) begin
      serial_out  <= ok_serial ? acc[SERIAL_W-1:0] : '0;
      day_out     <= ok_date ? (acc[DAY_W-1:0] + 1'b1) : '0;
      month_out   <= ok_date ? mcnt : '0;
      year_out    <= ok_date ? year_r : '0;
      range_error <= err_r;
    end
  end

  `ASSERT_IMPL(a_div_rem_in_cycle, clk, rst, cmd.year_fix, acc < ACC_W'(CYCLE_DAYS))
  `ASSERT_IMPL(a_walk_rem_in_year, clk, rst, cmd.month_step && ok_date, acc < ACC_W'(LEAP_DAYS))
  `ASSERT_IMPL(a_walk_month_bound, clk, rst, cmd.month_step, mcnt < MONTH_LAST)

endmodule

`default_nettype wire

[rtl/calendar_day_number_converter.sv]
// calendar day number converter: date to serial day number and back
// input beat: kind, day_of_month, month_in, year_in, serial_in; output beat: one result
// each input beat gives exactly one output beat, in order
// kind 0 walks the months before month_in
// kind 1 runs a reciprocal multiply and a remainder step for the divide by 1461, a year
//   split step and a month walk of up to 11 steps
// an out-of-range beat sets range_error with zero value fields
// one item is in work at a time; in_ready rises again the cycle after the result is loaded,
//   so the input takes no new beat before the current one is finished
// the result sits in an output register, so a new beat is accepted while it waits
// a stalled receiver holds the finished item in its last state until the register frees
// synchronous reset empties the output register and returns the sequencer to idle
// MAX_YEAR sets the upper bound of valid years and of valid serial numbers
// depends on cdn_pkg, cdn_ctrl and cdn_dp
`timescale 1ns / 1ps
`default_nettype none

module calendar_day_number_converter #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [cdn_pkg::DAY_W-1:0]    day_of_month,
  input  logic [cdn_pkg::MONTH_W-1:0]  month_in,
  input  logic [cdn_pkg::YEAR_W-1:0]   year_in,
  input  logic [cdn_pkg::SERIAL_W-1:0] serial_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cdn_pkg::SERIAL_W-1:0] serial_out,
  output logic [cdn_pkg::DAY_W-1:0]    day_out,
  output logic [cdn_pkg::MONTH_W-1:0]  month_out,
  output logic [cdn_pkg::YEAR_W-1:0]   year_out,
  output logic                         range_error
);
  import cdn_pkg::*;

  cdn_cmd_t    cmd;
  cdn_status_t status;

  cdn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cdn_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .kind         (kind),
    .day_of_month (day_of_month),
    .month_in     (month_in),
    .year_in      (year_in),
    .serial_in    (serial_in),
    .cmd          (cmd),
    .status       (status),
    .serial_out   (serial_out),
    .day_out      (day_out),
    .month_out    (month_out),
    .year_out     (year_out),
    .range_error  (range_error)
  );

endmodule

`default_nettype wire

[tb/day_number_checker.sv]
// result checker for the calendar day number converter: predicts each accepted input beat
// and compares the output beats in order; depends on cdn_pkg for widths and kind codes
`timescale 1ns / 1ps

module day_number_checker
  import cdn_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                kind,
  input  logic [DAY_W-1:0]    day_of_month,
  input  logic [MONTH_W-1:0]  month_in,
  input  logic [YEAR_W-1:0]   year_in,
  input  logic [SERIAL_W-1:0] serial_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [SERIAL_W-1:0] serial_out,
  input  logic [DAY_W-1:0]    day_out,
  input  logic [MONTH_W-1:0]  month_out,
  input  logic [YEAR_W-1:0]   year_out,
  input  logic                range_error,
  output int                  fail_count,
  output int                  outstanding
);

  localparam int unsigned FOUR_YEAR_DAYS = 1461;
  localparam int unsigned LAST_SERIAL    = (MAX_YEAR + 1) * 365 + MAX_YEAR / 4 + 1;

  typedef struct packed {
    logic [SERIAL_W-1:0] serial;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic                err;
  } conversion_t;

  conversion_t pending_conversions[$];
  conversion_t oldest;

  function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return (yr % 4 == 0) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic conversion_t convert_beat(input logic                k,
                                               input logic [DAY_W-1:0]    d,
                                               input logic [MONTH_W-1:0]  m,
                                               input logic [YEAR_W-1:0]   y,
                                               input logic [SERIAL_W-1:0] s);
    conversion_t res;
    int unsigned total, z, yr, rem, mon;
    res = '0;
    if (k == KIND_TO_SERIAL) begin
      if (m < MONTH_FIRST || m > MONTH_LAST || d == 0 || y > MAX_YEAR) begin
        res.err = 1'b1;
      end else begin
        yr = y;
        total = yr * 365 + (yr + 3) / 4;
        for (mon = 1; mon < m; mon++) total += month_length(mon, yr);
        total += d;
        res.serial = total[SERIAL_W-1:0];
      end
    end else begin
      if (s == 0 || s > LAST_SERIAL) begin
        res.err = 1'b1;
      end else begin
        z = s - 1;
        yr = (z / FOUR_YEAR_DAYS) * 4;
        rem = z % FOUR_YEAR_DAYS;
        // first year of each four-year cycle is the leap one
        if (rem >= 366) begin
          rem -= 366;
          yr += 1 + rem / 365;
          rem %= 365;
        end
        mon = 1;
        while (mon < 12 && rem >= month_length(mon, yr)) begin
          rem -= month_length(mon, yr);
          mon++;
        end
        res.day   = DAY_W'(rem + 1);
        res.month = MONTH_W'(mon);
        res.year  = YEAR_W'(yr);
      end
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_conversions.size() == 0) begin
          $error("result beat with nothing expected: serial_out %0d, range_error %0b",
                 serial_out, range_error);
          fail_count++;
        end else begin
          oldest = pending_conversions.pop_front();
          compare_field("serial_out", oldest.serial, serial_out);
          compare_field("day_out", oldest.day, day_out);
          compare_field("month_out", oldest.month, month_out);
          compare_field("year_out", oldest.year, year_out);
          compare_field("range_error", oldest.err, range_error);
        end
      end
      if (in_valid && in_ready)
        pending_conversions.push_back(convert_beat(kind, day_of_month, month_in, year_in,
                                                   serial_in));
    end
    outstanding <= pending_conversions.size();
  end

endmodule

[tb/tb_top.sv]
// testbench top for the calendar day number converter: clock, reset, stimulus and verdict
// depends on cdn_pkg, calendar_day_number_converter and day_number_checker
`timescale 1ns / 1ps

module tb_top;
  import cdn_pkg::*;

  localparam int unsigned MAX_YEAR    = 9999;
  localparam int unsigned LAST_SERIAL = (MAX_YEAR + 1) * 365 + MAX_YEAR / 4 + 1;
  localparam int RANDOM_PER_PHASE     = 320;
  localparam int DRAIN_CYCLES         = 40;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                kind         = KIND_TO_SERIAL;
  logic [DAY_W-1:0]    day_of_month = '0;
  logic [MONTH_W-1:0]  month_in     = '0;
  logic [YEAR_W-1:0]   year_in      = '0;
  logic [SERIAL_W-1:0] serial_in    = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [SERIAL_W-1:0] serial_out;
  logic [DAY_W-1:0]    day_out;
  logic [MONTH_W-1:0]  month_out;
  logic [YEAR_W-1:0]   year_out;
  logic                range_error;
  int                  fail_count;
  int                  outstanding;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int idle_by_phase[4]  = '{0, 83, 0, 22};
  int stall_by_phase[4] = '{0, 0, 83, 22};

  calendar_day_number_converter #(.MAX_YEAR(MAX_YEAR)) uut (.*);

  day_number_checker #(.MAX_YEAR(MAX_YEAR)) result_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_beat(input logic                k,
                           input logic [DAY_W-1:0]    d,
                           input logic [MONTH_W-1:0]  m,
                           input logic [YEAR_W-1:0]   y,
                           input logic [SERIAL_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    day_of_month <= d;
    month_in     <= m;
    year_in      <= y;
    serial_in    <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender until every result is back, then switch sender idling and receiver stalling
  task automatic drain_and_set(input int idle, input int stall);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    send_idle_pct <= idle;
    stall_pct     <= stall;
  endtask

  task automatic send_random_beat();
    logic [DAY_W-1:0]    d;
    logic [MONTH_W-1:0]  m;
    logic [YEAR_W-1:0]   y;
    logic [SERIAL_W-1:0] s;
    int unsigned         pick, yr;
    d = DAY_W'($urandom);
    m = MONTH_W'($urandom);
    y = YEAR_W'($urandom);
    s = SERIAL_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_beat(1'($urandom_range(1)), d, m, y, s);
    end else if (pick < 55) begin
      m = MONTH_W'($urandom_range(12, 1));
      d = ($urandom_range(9) == 0) ? DAY_W'($urandom_range(31, 29))
                                   : DAY_W'($urandom_range(28, 1));
      case ($urandom_range(7))
        0:       y = YEAR_W'(MAX_YEAR - $urandom_range(3));
        1:       y = YEAR_W'($urandom_range(3));
        default: y = YEAR_W'($urandom_range(MAX_YEAR));
      endcase
      send_beat(KIND_TO_SERIAL, d, m, y, s);
    end else begin
      case ($urandom_range(9))
        0:       s = SERIAL_W'($urandom_range(LAST_SERIAL, LAST_SERIAL - 400));
        1:       s = SERIAL_W'($urandom_range(400, 1));
        2, 3: begin
          // around new year, end of february or end of year
          yr = $urandom_range(MAX_YEAR);
          s = SERIAL_W'(yr * 365 + (yr + 3) / 4 + 1 + $urandom_range(2)
                        + (($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 57 : 363)));
        end
        default: s = SERIAL_W'($urandom_range(LAST_SERIAL, 1));
      endcase
      send_beat(KIND_TO_DATE, d, m, y, s);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // date to serial: first and last day, overrun days, leap februaries, bad fields
    send_beat(KIND_TO_SERIAL, 5'd1, 4'd1, 14'd0, '0);
    send_beat(KIND_TO_SERIAL, 5'd31, 4'd12, YEAR_W'(MAX_YEAR), '0);
    send_beat(KIND_TO_SERIAL, 5'd31, 4'd2, 14'd3, '0);
    send_beat(KIND_TO_SERIAL, 5'd29, 4'd2, 14'd4, '0);
    send_beat(KIND_TO_SERIAL, 5'd28, 4'd2, 14'd1, '0);
    send_beat(KIND_TO_SERIAL, 5'd1, 4'd3, 14'd0, '1);
    send_beat(KIND_TO_SERIAL, 5'd0, 4'd5, 14'd100, '0);
    send_beat(KIND_TO_SERIAL, 5'd15, 4'd0, 14'd100, '0);
    send_beat(KIND_TO_SERIAL, 5'd15, 4'd13, 14'd100, '0);
    send_beat(KIND_TO_SERIAL, '1, '1, '1, '1);
    send_beat(KIND_TO_SERIAL, 5'd1, 4'd1, YEAR_W'(MAX_YEAR + 1), '0);

    // serial to date: zero, first, leap day, year edges, last, past the last
    send_beat(KIND_TO_DATE, '1, '1, '1, '0);
    send_beat(KIND_TO_DATE, '0, '0, '0, 22'd1);
    send_beat(KIND_TO_DATE, '0, '0, '0, 22'd60);
    send_beat(KIND_TO_DATE, '0, '0, '0, 22'd61);
    send_beat(KIND_TO_DATE, '0, '0, '0, 22'd366);
    send_beat(KIND_TO_DATE, '0, '0, '0, 22'd367);
    send_beat(KIND_TO_DATE, '0, '0, '0, 22'd1461);
    send_beat(KIND_TO_DATE, '0, '0, '0, 22'd1462);
    send_beat(KIND_TO_DATE, '1, '1, '1, SERIAL_W'(LAST_SERIAL));
    send_beat(KIND_TO_DATE, '0, '0, '0, SERIAL_W'(LAST_SERIAL + 1));
    send_beat(KIND_TO_DATE, '0, '0, '0, '1);

    for (int phase = 0; phase < 4; phase++) begin
      drain_and_set(idle_by_phase[phase], stall_by_phase[phase]);
      repeat (RANDOM_PER_PHASE) send_random_beat();
    end

    drain_and_set(0, 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/cdn_pkg.sv
rtl/cdn_ctrl.sv
rtl/cdn_dp.sv
rtl/calendar_day_number_converter.sv
tb/day_number_checker.sv
tb/tb_top.sv
